### rtl/fmwrt_pkg.sv
// Package for the first-match wildcard route table.
// Holds operation and decision codes, rule kinds, the stored rule layout and
// the sequencer state type. Depends on nothing.
`default_nettype none

package fmwrt_pkg;

  localparam int RULE_CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_RESOLVE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DEC_DIRECT = 2'd0,
    DEC_VIA    = 2'd1,
    DEC_HOLD   = 2'd2
  } decision_t;

  localparam logic [2:0] KIND_DIRECT  = 3'd0;
  localparam logic [2:0] KIND_VIAHOST = 3'd1;
  localparam logic [2:0] KIND_VIAHUB  = 3'd2;
  localparam logic [2:0] KIND_VIA     = 3'd3;
  localparam logic [2:0] KIND_HOLD    = 3'd4;
  localparam logic [2:0] KIND_ABSHOLD = 3'd5;
  localparam logic [2:0] KIND_NOPOLL  = 3'd6;
  localparam logic [2:0] KIND_SKIP    = 3'd7;

  typedef struct packed {
    logic [15:0] zone;
    logic [15:0] net;
    logic [15:0] node;
  } addr_t;

  // One stored rule: pattern with care bits, then the action.
  typedef struct packed {
    addr_t      pat;
    logic [2:0] care;   // [2] zone, [1] net, [0] node
    logic [2:0] kind;
    addr_t      relay;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Outcome of checking one rule against a destination.
  typedef struct packed {
    logic      decides;
    decision_t decision;
    addr_t     relay;
  } eval_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

`default_nettype wire

### rtl/fmwrt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fmwrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/fmwrt_rule_eval.sv
// Shared compare unit: checks one stored rule against the destination and
// forms the routing outcome that rule would give. Depends on fmwrt_pkg.
`default_nettype none

module fmwrt_rule_eval (
  input  wire fmwrt_pkg::rule_t rule,
  input  wire fmwrt_pkg::addr_t dest,
  output      fmwrt_pkg::eval_t res
);
  import fmwrt_pkg::*;

  logic hit;

  assign hit = (!rule.care[2] || (rule.pat.zone == dest.zone)) &&
               (!rule.care[1] || (rule.pat.net  == dest.net))  &&
               (!rule.care[0] || (rule.pat.node == dest.node));

  always_comb begin
    res          = '0;
    res.decides  = hit;
    res.decision = DEC_DIRECT;
    case (rule.kind)
      KIND_DIRECT: begin
        res.decision = DEC_DIRECT;
      end
      KIND_VIAHOST: begin
        // The net host is the destination with node zero.
        res.decision   = DEC_VIA;
        res.relay.zone = dest.zone;
        res.relay.net  = dest.net;
      end
      KIND_VIAHUB, KIND_VIA: begin
        res.decision = DEC_VIA;
        res.relay    = rule.relay;
      end
      KIND_HOLD, KIND_ABSHOLD, KIND_NOPOLL: begin
        res.decision = DEC_HOLD;
      end
      default: begin
        // Undefined kind never decides; the scan moves on.
        res.decides = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/first_match_wildcard_route_table_top.sv
// First-match wildcard route table, top level. For clear and append the result
// strobes in the cycle after the transaction and start may follow.
// Resolve reads one rule per cycle from the rule RAM through its single read port
// into the shared compare unit and stops at the first rule that decides; busy
// holds start off until the result strobe cycle.
// The receiver cannot stall.
// Reset (rst_n, synchronous) empties the table; the RAM contents are not cleared.
// Depends on fmwrt_pkg, fmwrt_ram and fmwrt_rule_eval.
`default_nettype none

module first_match_wildcard_route_table_top #(
  parameter int RULE_CAPACITY = fmwrt_pkg::RULE_CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_addr_zone,
  input  wire logic [15:0] in_addr_net,
  input  wire logic [15:0] in_addr_node,
  input  wire logic        in_care_zone,
  input  wire logic        in_care_net,
  input  wire logic        in_care_node,
  input  wire logic [2:0]  in_rule_kind,
  input  wire logic [15:0] in_relay_zone_in,
  input  wire logic [15:0] in_relay_net_in,
  input  wire logic [15:0] in_relay_node_in,
  output      logic        out_valid,
  output      logic [1:0]  out_decision,
  output      logic [15:0] out_relay_zone,
  output      logic [15:0] out_relay_net,
  output      logic [15:0] out_relay_node,
  output      logic        out_accepted
);
  import fmwrt_pkg::*;

  // Address width for the RAM; count width can also hold the full capacity.
  localparam int AW = (RULE_CAPACITY > 1) ? $clog2(RULE_CAPACITY) : 1;
  localparam int CW = $clog2(RULE_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(RULE_CAPACITY);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;     // number of stored rules
  logic [CW-1:0] idx_r, idx_nxt;         // next rule to read during a scan
  logic          cmp_v_r, cmp_v_nxt;     // RAM output holds a rule to check
  addr_t         dest_r, dest_nxt;       // destination being resolved

  logic        out_valid_r, out_valid_nxt;
  decision_t   out_dec_r, out_dec_nxt;
  addr_t       out_relay_r, out_relay_nxt;
  logic        out_acc_r, out_acc_nxt;

  logic  accept;
  logic  room;
  logic  issue;
  logic  ram_we;
  rule_t wr_rule;
  rule_t rd_rule;
  eval_t eval;

  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;
  assign room   = (count_r < CAP);

  // A scan reads rule idx_r while the rule read in the previous cycle is checked.
  assign issue  = (state_r == ST_SCAN) && (idx_r < count_r);
  assign ram_we = accept && (func_t'(in_func) == FUNC_APPEND) && room;

  always_comb begin
    wr_rule            = '0;
    wr_rule.pat.zone   = in_addr_zone;
    wr_rule.pat.net    = in_addr_net;
    wr_rule.pat.node   = in_addr_node;
    wr_rule.care       = {in_care_zone, in_care_net, in_care_node};
    wr_rule.kind       = in_rule_kind;
    wr_rule.relay.zone = in_relay_zone_in;
    wr_rule.relay.net  = in_relay_net_in;
    wr_rule.relay.node = in_relay_node_in;
  end

  fmwrt_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_CAPACITY),
    .AW    (AW)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_rule),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_rule)
  );

  fmwrt_rule_eval u_eval (
    .rule (rd_rule),
    .dest (dest_r),
    .res  (eval)
  );

  // Next state: a resolve transaction enters the scan, which ends when a rule
  // decides or when every stored rule has been checked.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (func_t'(in_func) == FUNC_RESOLVE)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((cmp_v_r && eval.decides) || (!cmp_v_r && !issue)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath registers.
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_v_nxt     = 1'b0;
    dest_nxt      = dest_r;
    out_valid_nxt = 1'b0;
    out_dec_nxt   = out_dec_r;
    out_relay_nxt = out_relay_r;
    out_acc_nxt   = out_acc_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_dec_nxt   = DEC_DIRECT;
          out_relay_nxt = '0;
          out_acc_nxt   = 1'b1;
          case (func_t'(in_func))
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            FUNC_APPEND: begin
              if (room) begin
                count_nxt = count_r + CW'(1);
              end else begin
                out_acc_nxt = 1'b0;
              end
            end
            FUNC_RESOLVE: begin
              // The result is produced when the scan ends.
              out_valid_nxt = 1'b0;
              idx_nxt       = '0;
              dest_nxt      = '{zone: in_addr_zone, net: in_addr_net, node: in_addr_node};
            end
            default: begin
              // Unused operation code: the table is left as it is; the result still strobes.
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt   = idx_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end
        if (cmp_v_r && eval.decides) begin
          cmp_v_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_dec_nxt   = eval.decision;
          out_relay_nxt = eval.relay;
          out_acc_nxt   = 1'b1;
        end else if (!cmp_v_r && !issue) begin
          // No rule decided: route direct.
          out_valid_nxt = 1'b1;
          out_dec_nxt   = DEC_DIRECT;
          out_relay_nxt = '0;
          out_acc_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    dest_r      <= dest_nxt;
    out_dec_r   <= out_dec_nxt;
    out_relay_r <= out_relay_nxt;
    out_acc_r   <= out_acc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_decision   = out_dec_r;
  assign out_relay_zone = out_relay_r.zone;
  assign out_relay_net  = out_relay_r.net;
  assign out_relay_node = out_relay_r.node;
  assign out_accepted   = out_acc_r;

endmodule

`default_nettype wire
